// ===== src/msb_first_bit_reader_assert.svh =====
// Assertion macros for the MSB-first bit reader.
// Expects clk and rst_n in scope at the point of use.
`ifndef MSB_FIRST_BIT_READER_ASSERT_SVH
`define MSB_FIRST_BIT_READER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/msbr_pkg.sv =====
// Shared types and constants for the MSB-first bit reader.
// No dependencies.
package msbr_pkg;

  localparam int BYTE_BITS            = 8;
  localparam int DEFAULT_BUFFER_BYTES = 4096;
  // Compare width for byte counts and positions; covers buffers up to 65536 bytes.
  localparam int CMP_W                = 17;

  // Request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_REWIND = 2'd2;

  // Register index (word address bit 2)
  localparam logic REG_IDX_STREAM_BIT_LENGTH = 1'b0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [3:0]  bits_wanted;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [3:0]  bits_read;
    logic [15:0] bits_left;
  } out_item_t;

endpackage

// ===== src/msb_first_bit_reader.sv =====
// MSB-first bit reader: byte buffer in a two-read-port synchronous memory.
// Requests and buffer bytes are registered at accept; the result is registered once
// the output register is free. One request is in flight at a time; the memory read and
// the compute/write-back are interlocked, since each request moves the read position.
// Reset clears the read position, bit counters, length register and handshake state;
// the byte buffer is not cleared and holds undefined data until loaded.
module msb_first_bit_reader #(
  parameter int BUFFER_BYTES = msbr_pkg::DEFAULT_BUFFER_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  msbr_pkg::in_item_t in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output msbr_pkg::out_item_t out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int CMP_W = msbr_pkg::CMP_W;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [15:0]   len_r;       // stream length in bits
  logic [AW-1:0] pos_r;       // current byte position
  logic [3:0]    rib_r;       // unread bits in the current byte
  logic [15:0]   cons_r;      // bits consumed so far

  // request in flight (captured at accept, finished once the output register is free)
  logic          busy_r;
  logic [1:0]    op_r;
  logic [3:0]    want_r;
  logic [7:0]    rd0_r;       // byte at the effective position
  logic [7:0]    rd1_r;       // byte after it

  // output register
  logic                out_valid_r;
  msbr_pkg::out_item_t out_r;

  logic [7:0] byte_mem [BUFFER_BYTES];

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic accept;
  logic fire;
  logic cfg_wr;

  // One request in flight at a time; a waiting result does not block the next one.
  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  // Finish when the output register is empty or drains this cycle.
  assign fire     = busy_r && (!out_valid_r || !out_stall);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == msbr_pkg::REG_IDX_STREAM_BIT_LENGTH) ? {16'b0, len_r} : 32'b0;

  // ---------------------------------------------------------------------------
  // Position logic, shared by the read issue and the compute cycle.
  // Position state changes only at finish, so both see the same values unless len_r is written.
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] len_bytes;
  logic [CMP_W-1:0] size;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_inc;
  logic             adv;
  logic [CMP_W-1:0] p_ext;
  logic [CMP_W-1:0] p_inc;
  logic [3:0]       r_eff;

  assign len_bytes = (CMP_W'(len_r) + CMP_W'(7)) >> 3;
  assign size      = (len_bytes > CMP_W'(BUFFER_BYTES)) ? CMP_W'(BUFFER_BYTES) : len_bytes;
  assign pos_ext   = CMP_W'(pos_r);
  assign pos_inc   = pos_ext + CMP_W'(1);
  // Current byte exhausted: step to the next one if it is in the stream.
  assign adv       = (rib_r == 4'd0) && (pos_inc < size);
  assign p_ext     = adv ? pos_inc : pos_ext;
  assign p_inc     = p_ext + CMP_W'(1);
  assign r_eff     = adv ? 4'(msbr_pkg::BYTE_BITS) : rib_r;

  // ---------------------------------------------------------------------------
  // Byte buffer: one write port for loads, two read ports at p and p+1.
  // Read data is captured only at accept, so it holds while the result waits.
  // ---------------------------------------------------------------------------
  logic          load_ok;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;

  assign load_ok = (in_data.req_type == msbr_pkg::REQ_LOAD) &&
                   (CMP_W'(in_data.load_address) < CMP_W'(BUFFER_BYTES));
  assign wa  = AW'(in_data.load_address);
  assign ra0 = AW'(p_ext);
  assign ra1 = AW'(p_inc);   // wraps only where the second byte is not used

  always_ff @(posedge clk) begin
    if (accept && load_ok) begin
      byte_mem[wa] <= in_data.load_data;
    end
    if (accept) begin
      rd0_r <= byte_mem[ra0];
      rd1_r <= byte_mem[ra1];
    end
  end

  // ---------------------------------------------------------------------------
  // Bit extraction
  // ---------------------------------------------------------------------------
  logic [15:0]   rem;
  logic [3:0]    want_c;
  logic [3:0]    w;
  logic          rd_ok;
  logic [7:0]    rd_val;
  logic [AW-1:0] new_pos;
  logic [3:0]    new_rib;

  assign rem    = (cons_r < len_r) ? (len_r - cons_r) : 16'd0;
  assign want_c = (want_r > 4'(msbr_pkg::BYTE_BITS)) ? 4'(msbr_pkg::BYTE_BITS) : want_r;
  // Trim to the bits left; rem is then below 8, so the low nibble holds it.
  assign w      = ({12'b0, want_c} > rem) ? rem[3:0] : want_c;

  always_comb begin
    logic [7:0] top;
    logic [7:0] v0;
    logic [3:0] rest;
    rd_ok   = 1'b0;
    rd_val  = 8'd0;
    new_pos = pos_r;
    new_rib = rib_r;
    top     = rd0_r << (4'd8 - r_eff);
    v0      = top >> (4'd8 - w);
    rest    = r_eff + 4'd8 - w;
    if (want_c != 4'd0 && cons_r < len_r && r_eff != 4'd0 &&
        r_eff <= 4'(msbr_pkg::BYTE_BITS) && p_ext < size) begin
      if (w > r_eff) begin
        // Span into the next byte, which must also lie in the stream.
        if (p_inc < size) begin
          rd_ok   = 1'b1;
          rd_val  = v0 | (rd1_r >> rest);
          new_pos = AW'(p_inc);
          new_rib = rest;
        end
      end else begin
        rd_ok   = 1'b1;
        rd_val  = v0;
        new_pos = AW'(p_ext);
        new_rib = r_eff - w;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Write-back and result
  // ---------------------------------------------------------------------------
  msbr_pkg::out_item_t res;

  always_comb begin
    res.read_value = 8'd0;
    res.bits_read  = 4'd0;
    res.bits_left  = rem;
    unique case (op_r)
      msbr_pkg::REQ_READ: begin
        if (rd_ok) begin
          res.read_value = rd_val;
          res.bits_read  = w;
          res.bits_left  = rem - {12'b0, w};
        end
      end
      msbr_pkg::REQ_REWIND: begin
        res.bits_left = len_r;
      end
      default: begin
        // load and the unused code report the bits left only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= 16'd0;
      pos_r       <= '0;
      rib_r       <= 4'(msbr_pkg::BYTE_BITS);
      cons_r      <= 16'd0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == msbr_pkg::REG_IDX_STREAM_BIT_LENGTH) begin
        len_r <= pwdata[15:0];
      end

      // Hold the request until its result can move to the output register.
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end

      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        if (op_r == msbr_pkg::REQ_READ && rd_ok) begin
          pos_r  <= new_pos;
          rib_r  <= new_rib;
          cons_r <= cons_r + {12'b0, w};
        end else if (op_r == msbr_pkg::REQ_REWIND) begin
          pos_r  <= '0;
          rib_r  <= 4'(msbr_pkg::BYTE_BITS);
          cons_r <= 16'd0;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_data.req_type;
      want_r <= in_data.bits_wanted;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "msb_first_bit_reader_assert.svh"

  `ASSERT_ALWAYS(a_rib_range, rib_r <= 4'(msbr_pkg::BYTE_BITS), "bits in byte above eight")
  `ASSERT_IMPLIES(a_cnt_range, out_valid_r, out_r.bits_read <= 4'(msbr_pkg::BYTE_BITS), "bits_read above eight")
  `ASSERT_IMPLIES(a_zero_val, out_valid_r && out_r.bits_read == 4'd0, out_r.read_value == 8'd0, "value without bits")
  `ASSERT_IMPLIES(a_left_len, out_valid_r, out_r.bits_left <= len_r, "bits_left above length")

endmodule
